### hw/rtl/assm_pkg.sv
// Shared types, constants and the tanh table of the analog stage sample unit.
package assm_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int TANH_ENTRIES = 256;
  localparam int IDX_W        = $clog2(TANH_ENTRIES);
  localparam int TANH_W       = FRAC_BITS + 1;
  // |x| saturates at 8.0, which needs FRAC_BITS + 4 bits
  localparam int ABS_W        = FRAC_BITS + 4;
  localparam int POS_W        = ABS_W + IDX_W - 3;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int BIAS_W   = 15;
  localparam int INVB_W   = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int AMP_W   = 27;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_RELAX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOWPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AMP     = 2'd2;

  localparam logic [MODE_W-1:0] RST_MODE = MODE_LOWPASS;
  localparam logic [COEF_W-1:0] RST_COEF = 16'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN = 16'd25600;
  localparam logic [BIAS_W-1:0] RST_BIAS = 15'd10240;
  localparam logic [INVB_W-1:0] RST_INVB = 16'd1638;

  // capacitor limits (+-5 V) and target (2.5 V), one volt for the output clamp
  localparam logic signed [18:0] LEVEL_MAX  = 19'(5 * (1 << FRAC_BITS));
  localparam logic signed [16:0] LEVEL_TGT  = 17'((5 * (1 << FRAC_BITS)) / 2);
  localparam logic signed [16:0] VOLT_ONE   = 17'(1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] TANH_LIM = PROD_W'(8 * (1 << FRAC_BITS));

  localparam logic signed [PROD_W-1:0] HALF_8  = PROD_W'(1 << 7);
  localparam logic signed [PROD_W-1:0] HALF_16 = PROD_W'(1 << 15);
  localparam logic signed [PROD_W-1:0] HALF_FB = PROD_W'(1 << (FRAC_BITS - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 3'd0,
    CFG_COEF = 3'd1,
    CFG_GAIN = 3'd2,
    CFG_BIAS = 3'd3,
    CFG_INVB = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_RELAX,
    OP_LOWPASS,
    OP_AMP,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_UPD_A,
    ST_MUL_B,
    ST_ARG,
    ST_LOOK,
    ST_MUL_C,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COEF_W-1:0] coef;
    logic [GAIN_W-1:0] gain;
    logic [BIAS_W-1:0] bias;
    logic [INVB_W-1:0] invb;
  } cfg_t;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic pop;
    logic done;
  } back_stat_t;

  typedef logic [TANH_W-1:0] tanh_tab_t [TANH_ENTRIES];

  // Restoring long division of 64-bit unsigned values; used only while the
  // table below is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i is tanh(8*i/TANH_ENTRIES): series for tanh(h), then the addition
  // formula step by step, all in Q30 integer arithmetic. Evaluated once.
  function automatic tanh_tab_t build_tanh_table();
    longint unsigned one, h, h2, sh, ch, ts, tc, t, cur, den;
    tanh_tab_t tab;
    one = 64'd1 << 30;
    h   = (64'd8 << 30) / TANH_ENTRIES;
    h2  = (h * h) >> 30;
    sh  = h;
    ch  = one;
    ts  = h;
    tc  = one;
    cur = 64'd0;
    for (int k = 1; k <= 12; k++) begin
      ts = udiv64((ts * h2) >> 30, 64'((2 * k) * (2 * k + 1)));
      tc = udiv64((tc * h2) >> 30, 64'((2 * k - 1) * (2 * k)));
      sh = sh + ts;
      ch = ch + tc;
    end
    t = udiv64(sh << 30, ch);
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      tab[i] = TANH_W'((cur + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      den    = one + ((cur * t) >> 30);
      cur    = udiv64((cur + t) << 30, den);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TABLE = build_tanh_table();

endpackage

### hw/rtl/assm_front.sv
// Front end: configuration registers, input accept and mode classification.
module assm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [assm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [assm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [assm_pkg::SAMPLE_W-1:0]     in_data_i,
  output logic                              push_o,
  input  logic                              push_ready_i,
  output assm_pkg::qent_t                   push_data_o,
  output assm_pkg::cfg_t                    cfg_o
);

  assm_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= assm_pkg::RST_MODE;
      cfg_q.coef <= assm_pkg::RST_COEF;
      cfg_q.gain <= assm_pkg::RST_GAIN;
      cfg_q.bias <= assm_pkg::RST_BIAS;
      cfg_q.invb <= assm_pkg::RST_INVB;
    end else if (cfg_valid_i) begin
      case (assm_pkg::cfg_idx_e'(cfg_index_i))
        assm_pkg::CFG_MODE: cfg_q.mode <= cfg_data_i[assm_pkg::MODE_W-1:0];
        assm_pkg::CFG_COEF: cfg_q.coef <= cfg_data_i[assm_pkg::COEF_W-1:0];
        assm_pkg::CFG_GAIN: cfg_q.gain <= cfg_data_i[assm_pkg::GAIN_W-1:0];
        assm_pkg::CFG_BIAS: cfg_q.bias <= cfg_data_i[assm_pkg::BIAS_W-1:0];
        assm_pkg::CFG_INVB: cfg_q.invb <= cfg_data_i[assm_pkg::INVB_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  // tag each item with the operation it needs under the current mode
  always_comb begin
    push_data_o.sample = $signed(in_data_i);
    case (cfg_q.mode)
      assm_pkg::MODE_RELAX:   push_data_o.op = assm_pkg::OP_RELAX;
      assm_pkg::MODE_LOWPASS: push_data_o.op = assm_pkg::OP_LOWPASS;
      assm_pkg::MODE_AMP:     push_data_o.op = assm_pkg::OP_AMP;
      default:                push_data_o.op = assm_pkg::OP_NONE;
    endcase
  end

endmodule

### hw/rtl/assm_queue.sv
// Short shift queue between front end and back end; head sits in slot zero.
module assm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  assm_pkg::qent_t   push_data_i,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output assm_pkg::qent_t   pop_data_o,
  output assm_pkg::qstat_t  stat_o
);

  assm_pkg::qent_t                slot_q [assm_pkg::QUEUE_DEPTH];
  logic [assm_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic [assm_pkg::QCNT_W-1:0]    wr_idx;

  assign stat_o.full   = (cnt_q == assm_pkg::QCNT_W'(assm_pkg::QUEUE_DEPTH));
  assign stat_o.empty  = (cnt_q == '0);
  assign push_ready_o  = !stat_o.full;
  assign pop_valid_o   = !stat_o.empty;
  assign pop_data_o    = slot_q[0];

  assign wr_idx = pop_i ? cnt_q - 1'b1 : cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < assm_pkg::QUEUE_DEPTH; j++) begin
      if (push_i && (wr_idx == assm_pkg::QCNT_W'(j))) begin
        slot_q[j] <= push_data_i;
      end else if (pop_i && (j < assm_pkg::QUEUE_DEPTH - 1)) begin
        slot_q[j] <= slot_q[(j < assm_pkg::QUEUE_DEPTH - 1) ? j + 1 : j];
      end
    end
  end

endmodule

### hw/rtl/assm_back.sv
// Back end: sequencer around one shared multiplier, tanh lookup, result register.
module assm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  assm_pkg::cfg_t                    cfg_i,
  input  logic                              q_valid_i,
  input  assm_pkg::qent_t                   q_data_i,
  output assm_pkg::back_stat_t              stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [assm_pkg::SAMPLE_W-1:0]     out_data_o
);

  assm_pkg::state_e state_q, state_d;

  assm_pkg::op_e                       op_q;
  logic signed [assm_pkg::SAMPLE_W-1:0] x_q;
  logic signed [assm_pkg::SAMPLE_W-1:0] cap_q, cap_d;
  logic signed [assm_pkg::SAMPLE_W-1:0] filt_q, filt_d;
  logic signed [assm_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic signed [assm_pkg::AMP_W-1:0]    amp_q, amp_d;
  logic [assm_pkg::IDX_W-1:0]           idx_q, idx_d;
  logic [assm_pkg::FRAC_BITS-1:0]       frac_q, frac_d;
  logic                                 neg_q, neg_d;
  logic                                 last_q, last_d;
  logic [assm_pkg::TANH_W-1:0]          lo_q;
  logic signed [assm_pkg::TANH_W:0]     diff_q, diff_d;
  logic                                 out_valid_q;
  logic [assm_pkg::SAMPLE_W-1:0]        out_data_q;

  logic                                 out_free;
  logic                                 pop, done;
  logic [assm_pkg::SAMPLE_W-1:0]        result;
  logic signed [assm_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [assm_pkg::MUL_B_W-1:0]  mul_b;

  logic signed [assm_pkg::PROD_W-1:0]   rnd16, rnd8, rndfb, targ;
  logic signed [18:0]                   cap_sum, filt_sum;
  logic signed [16:0]                   bias17;
  logic [assm_pkg::ABS_W-1:0]           mag;
  logic [assm_pkg::POS_W-1:0]           pos;
  logic [assm_pkg::IDX_W:0]             seg;
  logic signed [16:0]                   yval;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign stat_o.pop  = pop;
  assign stat_o.done = done;

  assign bias17 = $signed({2'b00, cfg_i.bias});
  assign rnd16  = (prod_q + assm_pkg::HALF_16) >>> 16;
  assign rnd8   = (prod_q + assm_pkg::HALF_8) >>> 8;
  assign rndfb  = (prod_q + assm_pkg::HALF_FB) >>> assm_pkg::FRAC_BITS;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      assm_pkg::ST_IDLE: begin
        if (q_valid_i && (q_data_i.op != assm_pkg::OP_NONE)) begin
          state_d = assm_pkg::ST_MUL_A;
        end
      end
      assm_pkg::ST_MUL_A: state_d = assm_pkg::ST_UPD_A;
      assm_pkg::ST_UPD_A: begin
        if (op_q != assm_pkg::OP_LOWPASS) begin
          state_d = assm_pkg::ST_MUL_B;
        end else if (out_free) begin
          state_d = assm_pkg::ST_IDLE;
        end
      end
      assm_pkg::ST_MUL_B: state_d = assm_pkg::ST_ARG;
      assm_pkg::ST_ARG:   state_d = assm_pkg::ST_LOOK;
      assm_pkg::ST_LOOK:  state_d = assm_pkg::ST_MUL_C;
      assm_pkg::ST_MUL_C: state_d = assm_pkg::ST_FIN;
      assm_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = assm_pkg::ST_IDLE;
        end
      end
      default: state_d = assm_pkg::ST_IDLE;
    endcase
  end

  // datapath control and shared multiplier operands
  always_comb begin
    pop      = 1'b0;
    done     = 1'b0;
    result   = '0;
    mul_a    = '0;
    mul_b    = '0;
    cap_d    = cap_q;
    filt_d   = filt_q;
    amp_d    = amp_q;
    idx_d    = idx_q;
    frac_d   = frac_q;
    neg_d    = neg_q;
    last_d   = last_q;
    diff_d   = diff_q;
    cap_sum  = $signed({{3{cap_q[15]}}, cap_q}) + rnd16[18:0];
    filt_sum = $signed({{3{filt_q[15]}}, filt_q}) + rnd16[18:0];
    targ     = (op_q == assm_pkg::OP_RELAX) ? rnd8 : rndfb;
    mag      = '0;
    pos      = '0;
    seg      = '0;
    yval     = '0;
    case (state_q)
      assm_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.op != assm_pkg::OP_NONE) begin
            pop = 1'b1;
          end else if (out_free) begin
            // unused mode: zero out, nothing else moves
            pop  = 1'b1;
            done = 1'b1;
          end
        end
      end
      assm_pkg::ST_MUL_A: begin
        case (op_q)
          assm_pkg::OP_RELAX: begin
            mul_a = assm_pkg::MUL_A_W'(assm_pkg::LEVEL_TGT - $signed({cap_q[15], cap_q}));
            mul_b = $signed({1'b0, cfg_i.coef});
          end
          assm_pkg::OP_LOWPASS: begin
            mul_a = assm_pkg::MUL_A_W'($signed({x_q[15], x_q}) - $signed({filt_q[15], filt_q}));
            mul_b = $signed({1'b0, cfg_i.coef});
          end
          default: begin
            mul_a = assm_pkg::MUL_A_W'($signed({x_q[15], x_q}) - bias17);
            mul_b = $signed({1'b0, cfg_i.gain});
          end
        endcase
      end
      assm_pkg::ST_UPD_A: begin
        case (op_q)
          assm_pkg::OP_RELAX: begin
            if (cap_sum > assm_pkg::LEVEL_MAX) begin
              cap_d = assm_pkg::SAMPLE_W'(assm_pkg::LEVEL_MAX);
            end else if (cap_sum < -assm_pkg::LEVEL_MAX) begin
              cap_d = assm_pkg::SAMPLE_W'(-assm_pkg::LEVEL_MAX);
            end else begin
              cap_d = cap_sum[assm_pkg::SAMPLE_W-1:0];
            end
          end
          assm_pkg::OP_LOWPASS: begin
            if (filt_sum > 19'sd32767) begin
              result = 16'h7FFF;
            end else if (filt_sum < -19'sd32768) begin
              result = 16'h8000;
            end else begin
              result = filt_sum[assm_pkg::SAMPLE_W-1:0];
            end
            if (out_free) begin
              done   = 1'b1;
              filt_d = $signed(result);
            end
          end
          default: begin
            amp_d = $signed(rnd8[assm_pkg::AMP_W-1:0]) +
                    $signed({{(assm_pkg::AMP_W - 17){1'b0}}, bias17});
          end
        endcase
      end
      assm_pkg::ST_MUL_B: begin
        if (op_q == assm_pkg::OP_RELAX) begin
          mul_a = assm_pkg::MUL_A_W'($signed({cap_q[15], cap_q}) - bias17);
          mul_b = $signed({1'b0, cfg_i.gain});
        end else begin
          mul_a = assm_pkg::MUL_A_W'(amp_q);
          mul_b = $signed({1'b0, cfg_i.invb});
        end
      end
      assm_pkg::ST_ARG: begin
        // saturate |x| to 8.0, then split the table position
        if ((targ > assm_pkg::TANH_LIM) || (targ < -assm_pkg::TANH_LIM)) begin
          mag = assm_pkg::ABS_W'(assm_pkg::TANH_LIM);
        end else if (targ < 0) begin
          mag = assm_pkg::ABS_W'(-targ);
        end else begin
          mag = assm_pkg::ABS_W'(targ);
        end
        pos    = {mag, {(assm_pkg::IDX_W - 3){1'b0}}};
        seg    = pos[assm_pkg::POS_W-1:assm_pkg::FRAC_BITS];
        frac_d = pos[assm_pkg::FRAC_BITS-1:0];
        neg_d  = targ < 0;
        last_d = seg >= (assm_pkg::IDX_W + 1)'(assm_pkg::TANH_ENTRIES - 1);
        idx_d  = last_d ? assm_pkg::IDX_W'(assm_pkg::TANH_ENTRIES - 1)
                        : seg[assm_pkg::IDX_W-1:0];
      end
      assm_pkg::ST_LOOK: begin
        if (last_q) begin
          diff_d = '0;
        end else begin
          diff_d = $signed({1'b0, assm_pkg::TANH_TABLE[idx_q + 1'b1]}) -
                   $signed({1'b0, assm_pkg::TANH_TABLE[idx_q]});
        end
      end
      assm_pkg::ST_MUL_C: begin
        mul_a = assm_pkg::MUL_A_W'(diff_q);
        mul_b = $signed({{(assm_pkg::MUL_B_W - assm_pkg::FRAC_BITS){1'b0}}, frac_q});
      end
      assm_pkg::ST_FIN: begin
        yval = $signed({{(17 - assm_pkg::TANH_W){1'b0}}, lo_q}) + rndfb[16:0];
        if (neg_q) begin
          yval = -yval;
        end
        if (op_q == assm_pkg::OP_RELAX) begin
          if (yval > assm_pkg::VOLT_ONE) begin
            yval = assm_pkg::VOLT_ONE;
          end else if (yval < -assm_pkg::VOLT_ONE) begin
            yval = -assm_pkg::VOLT_ONE;
          end
        end
        if (yval > 17'sd32767) begin
          result = 16'h7FFF;
        end else if (yval < -17'sd32768) begin
          result = 16'h8000;
        end else begin
          result = yval[assm_pkg::SAMPLE_W-1:0];
        end
        done = out_free;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= assm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cap_q       <= '0;
      filt_q      <= '0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      filt_q  <= filt_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q <= q_data_i.op;
      x_q  <= q_data_i.sample;
    end
    if (done) begin
      out_data_q <= result;
    end
    if (state_q == assm_pkg::ST_LOOK) begin
      lo_q <= assm_pkg::TANH_TABLE[idx_q];
    end
    // hold the product while a finishing state waits for the output register
    if ((state_q == assm_pkg::ST_MUL_A) || (state_q == assm_pkg::ST_MUL_B) ||
        (state_q == assm_pkg::ST_MUL_C)) begin
      prod_q <= prod_d;
    end
    amp_q  <= amp_d;
    idx_q  <= idx_d;
    frac_q <= frac_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    diff_q <= diff_d;
  end

endmodule

### hw/rtl/analog_stage_sample_model_unit.sv
// Top level of the analog stage sample unit: front end, queue, back end.
//
// Usage:
//   s_axis carries one input item per sample tick: tdata[15:0] = sample_in,
//   signed Q3.12. m_axis returns exactly one item per input item, in order:
//   tdata[15:0] = sample_out, signed Q3.12, saturated.
//   The cfg channel writes register cfg_index_i with cfg_data_i (0 mode,
//   1 step coefficient, 2 gain, 3 bias, 4 inverse bias); other indexes are
//   dropped. cfg_ready_o is always high. Write only while no item is in flight.
// Datapath:
//   Every item passes a two-entry queue, then a sequencer that shares one
//   28x17 multiplier. Lowpass items pass states MUL_A and UPD_A; relaxation
//   and amplifier items go on through MUL_B, ARG, LOOK, MUL_C and FIN (three
//   multiplies plus the tanh table step); the unused mode finishes in idle.
//   The back end takes a new item only after its last result has gone to
//   the output register.
// Reset:
//   Registers return to their defaults (lowpass mode), both levels clear,
//   the queue and output register empty. The tanh table is a constant.
// Stall:
//   A stalled m_axis holds its item; the back end then holds its finished
//   result, the queue fills, and s_axis_tready drops once the queue is full.
module analog_stage_sample_model_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [15:0] sample_out
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [assm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [assm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  assm_pkg::cfg_t        cfg;
  assm_pkg::qent_t       push_data, pop_data;
  assm_pkg::qstat_t      q_stat;
  assm_pkg::back_stat_t  back_stat;
  logic                  push, push_ready, pop_valid;

  // accept items and tag them with the current mode
  assm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .cfg_o        (cfg)
  );

  // decouple accept from the multi-cycle back end
  assm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (back_stat.pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .stat_o       (q_stat)
  );

  // run the selected mode and hold the result for m_axis
  assm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (pop_valid),
    .q_data_i     (pop_data),
    .stat_o       (back_stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("push into full queue");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) back_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a finished result only lands in a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites pending output");

  // a finished result shows up on m_axis in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) back_stat.done |=> m_axis_tvalid)
    else $error("finished result not presented");
`endif

endmodule

### test/analog_stage_sample_model_unit_test.sv
// Self-checking bench for the analog stage unit: random and edge samples in every mode.
module analog_stage_sample_model_unit_test;

  // Mode code that the block leaves unused: output zero, state untouched.
  localparam logic [assm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Number of writable registers; indexes at or above it are dropped.
  localparam int CFG_REGS    = 5;
  localparam int RAND_PHASES = 15;
  localparam int PHASE_ITEMS = 69;
  // Covers the longest back-end pass (relaxation or amplifier) plus the output register.
  localparam int DRAIN_GAP   = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 200;
  localparam longint SAT_HI  = 32767;
  localparam longint SAT_LO  = -32768;

  // Predicts sample_out for each accepted item and holds the results still owed.
  class stage_scoreboard;
    logic [assm_pkg::MODE_W-1:0]   mode;
    logic [assm_pkg::COEF_W-1:0]   coef;
    logic [assm_pkg::GAIN_W-1:0]   gain;
    logic [assm_pkg::BIAS_W-1:0]   bias;
    logic [assm_pkg::INVB_W-1:0]   invb;
    longint                        cap_lvl;
    longint                        flt_lvl;
    longint                        tanh_lut [assm_pkg::TANH_ENTRIES];
    logic [assm_pkg::SAMPLE_W-1:0] owed_out [$];

    function new();
      longint unsigned one, h, h2, sh, ch, ts, tc, t, cur, den;
      mode    = assm_pkg::RST_MODE;
      coef    = assm_pkg::RST_COEF;
      gain    = assm_pkg::RST_GAIN;
      bias    = assm_pkg::RST_BIAS;
      invb    = assm_pkg::RST_INVB;
      cap_lvl = 0;
      flt_lvl = 0;
      // tanh(h) from its series, then tanh(a+h) stepwise, all in Q30
      one = 64'd1 << 30;
      h   = (64'd8 << 30) / assm_pkg::TANH_ENTRIES;
      h2  = (h * h) >> 30;
      sh  = h;
      ch  = one;
      ts  = h;
      tc  = one;
      cur = 0;
      for (int k = 1; k <= 12; k++) begin
        ts = ((ts * h2) >> 30) / 64'((2 * k) * (2 * k + 1));
        tc = ((tc * h2) >> 30) / 64'((2 * k - 1) * (2 * k));
        sh = sh + ts;
        ch = ch + tc;
      end
      t = (sh << 30) / ch;
      for (int i = 0; i < assm_pkg::TANH_ENTRIES; i++) begin
        tanh_lut[i] = longint'((cur + (64'd1 << (29 - assm_pkg::FRAC_BITS)))
                               >> (30 - assm_pkg::FRAC_BITS));
        den = one + ((cur * t) >> 30);
        cur = ((cur + t) << 30) / den;
      end
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint tanh_q(longint x);
      longint a, p, idx, frac, d, y;
      a = (x < 0) ? -x : x;
      if (a > (longint'(8) << assm_pkg::FRAC_BITS)) a = longint'(8) << assm_pkg::FRAC_BITS;
      p    = (a * assm_pkg::TANH_ENTRIES) >>> 3;
      idx  = p >>> assm_pkg::FRAC_BITS;
      frac = p & ((longint'(1) << assm_pkg::FRAC_BITS) - 1);
      if (idx >= assm_pkg::TANH_ENTRIES - 1) begin
        y = tanh_lut[assm_pkg::TANH_ENTRIES-1];
      end else begin
        d = tanh_lut[int'(idx) + 1] - tanh_lut[int'(idx)];
        y = tanh_lut[int'(idx)] + round_shift(d * frac, assm_pkg::FRAC_BITS);
      end
      return (x < 0) ? -y : y;
    endfunction

    function void set_reg(logic [assm_pkg::CFG_IDX_W-1:0] idx,
                          logic [assm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        assm_pkg::CFG_MODE: mode = val[assm_pkg::MODE_W-1:0];
        assm_pkg::CFG_COEF: coef = val[assm_pkg::COEF_W-1:0];
        assm_pkg::CFG_GAIN: gain = val[assm_pkg::GAIN_W-1:0];
        assm_pkg::CFG_BIAS: bias = val[assm_pkg::BIAS_W-1:0];
        assm_pkg::CFG_INVB: invb = val[assm_pkg::INVB_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one sample tick and queue the sample it owes.
    function void note_tick(logic [assm_pkg::SAMPLE_W-1:0] raw);
      longint x, b, one, y, lv, amp;
      x   = longint'(signed'(raw));
      b   = longint'(bias);
      one = longint'(1) << assm_pkg::FRAC_BITS;
      y   = 0;
      case (mode)
        assm_pkg::MODE_RELAX: begin
          lv = cap_lvl + round_shift(longint'(coef) * ((5 * one >>> 1) - cap_lvl), 16);
          lv = clip(clip(lv, -5 * one, 5 * one), SAT_LO, SAT_HI);
          cap_lvl = lv;
          y = tanh_q(round_shift(longint'(gain) * (lv - b), 8));
          y = clip(y, -one, one);
        end
        assm_pkg::MODE_LOWPASS: begin
          flt_lvl = clip(flt_lvl + round_shift(longint'(coef) * (x - flt_lvl), 16),
                         SAT_LO, SAT_HI);
          y = flt_lvl;
        end
        assm_pkg::MODE_AMP: begin
          amp = round_shift(longint'(gain) * (x - b), 8) + b;
          y = tanh_q(round_shift(amp * longint'(invb), assm_pkg::FRAC_BITS));
        end
        default: y = 0;
      endcase
      owed_out.push_back(assm_pkg::SAMPLE_W'(clip(y, SAT_LO, SAT_HI)));
    endfunction

    // Compare one returned sample with the oldest owed one; explain any miss.
    function bit check_out(logic [assm_pkg::SAMPLE_W-1:0] got, output string why);
      logic [assm_pkg::SAMPLE_W-1:0] want;
      why = "";
      if (owed_out.size() == 0) begin
        why = $sformatf("sample_out %0d arrived with nothing owed", signed'(got));
        return 1'b0;
      end
      want = owed_out.pop_front();
      if (got !== want) begin
        why = $sformatf("sample_out got %0d want %0d", signed'(got), signed'(want));
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [15:0]                       s_axis_tdata  = '0;   // [15:0] sample_in
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [15:0]                       m_axis_tdata;         // [15:0] sample_out
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [assm_pkg::CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [assm_pkg::CFG_DATA_W-1:0]   cfg_data_i    = '0;

  stage_scoreboard sb;
  int    fail_count  = 0;
  int    cycle_count = 0;
  bit    steady      = 1'b0;   // set: neither side idles
  string miss_msg;

  analog_stage_sample_model_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge. Check the output first: a result
  // can never belong to an item accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (!sb.check_out(m_axis_tdata, miss_msg)) report_mismatch(miss_msg);
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
    end
  end

  // Stall the output side in about 9 percent of cycles, never while steady.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 9);
  end

  // Offer one item; hold tvalid high afterwards so back-to-back items never
  // drop it. Idle first at random, lowering tvalid for the gap.
  task automatic push_sample(input logic [assm_pkg::SAMPLE_W-1:0] smp);
    while (!steady && ($urandom_range(99) < 9)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop tvalid, wait until every owed sample is back, then let the block go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_out.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // One register write; cfg_valid_i stays high for the next write.
  task automatic write_reg(input logic [assm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [assm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Reprogram every register while idle, plus one write to an unused index
  // that the block must drop.
  task automatic configure(input logic [assm_pkg::MODE_W-1:0] m,
                           input logic [assm_pkg::COEF_W-1:0] c,
                           input logic [assm_pkg::GAIN_W-1:0] g,
                           input logic [assm_pkg::BIAS_W-1:0] b,
                           input logic [assm_pkg::INVB_W-1:0] ib);
    settle();
    write_reg(assm_pkg::CFG_MODE, assm_pkg::CFG_DATA_W'(m));
    write_reg(assm_pkg::CFG_COEF, c);
    write_reg(assm_pkg::CFG_GAIN, g);
    write_reg(assm_pkg::CFG_BIAS, assm_pkg::CFG_DATA_W'(b));
    write_reg(assm_pkg::CFG_INVB, ib);
    write_reg(assm_pkg::CFG_IDX_W'($urandom_range(CFG_REGS, (1 << assm_pkg::CFG_IDX_W) - 1)),
              assm_pkg::CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly random, with the ends of the range now and then.
  function automatic logic [15:0] pick_edge(input logic [15:0] top);
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return top;
    return 16'($urandom_range(top));
  endfunction

  function automatic logic [assm_pkg::SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return '0;
    return assm_pkg::SAMPLE_W'($urandom);
  endfunction

  initial begin
    int                          r;
    logic [assm_pkg::MODE_W-1:0] m;
    logic [assm_pkg::COEF_W-1:0] c;
    logic [assm_pkg::GAIN_W-1:0] g;
    logic [assm_pkg::BIAS_W-1:0] b;
    logic [assm_pkg::INVB_W-1:0] ib;

    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: lowpass with a zero coefficient holds the level at zero.
    push_sample(16'h7FFF);
    push_sample(16'h8000);

    // Fastest lowpass: full-scale swings both ways.
    configure(assm_pkg::MODE_LOWPASS, 16'hFFFF, assm_pkg::RST_GAIN, assm_pkg::RST_BIAS,
              assm_pkg::RST_INVB);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h7FFF);

    // Relaxation at full gain and zero bias, then at full bias: both tanh rails.
    configure(assm_pkg::MODE_RELAX, 16'hFFFF, 16'hFFFF, '0, assm_pkg::RST_INVB);
    push_sample(16'h1234);
    push_sample(16'h8000);
    configure(assm_pkg::MODE_RELAX, 16'h0001, 16'h0100, 15'h7FFF, 16'hFFFF);
    push_sample(16'h7FFF);
    push_sample(16'h0000);

    // Unity-gain amplifier at default bias, then zero bias with full inverse.
    configure(assm_pkg::MODE_AMP, assm_pkg::RST_COEF, 16'h0100, assm_pkg::RST_BIAS,
              assm_pkg::RST_INVB);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h2800);
    configure(assm_pkg::MODE_AMP, '0, '0, '0, 16'hFFFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);

    // Unused mode: zero out, levels untouched for the next lowpass phase.
    configure(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 15'h7FFF, '0);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    configure(assm_pkg::MODE_LOWPASS, 16'h8000, 16'h0000, 15'h0000, 16'h0000);
    push_sample(16'h4000);

    // Random phases: odd ones keep gain and inverse bias moderate so tanh
    // lands on the sloped part of the table rather than the rails.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(9);
      m = (r < 3) ? assm_pkg::MODE_RELAX :
          (r < 6) ? assm_pkg::MODE_LOWPASS :
          (r < 9) ? assm_pkg::MODE_AMP : MODE_UNUSED;
      c = pick_edge(16'hFFFF);
      b = assm_pkg::BIAS_W'(pick_edge(16'h7FFF));
      if (ph % 2 == 1) begin
        g  = assm_pkg::GAIN_W'($urandom_range(64, 1024));
        ib = assm_pkg::INVB_W'($urandom_range(256, 4096));
      end else begin
        g  = pick_edge(16'hFFFF);
        ib = pick_edge(16'hFFFF);
      end
      configure(m, c, g, b, ib);
      // Hold a long stretch with no idling on either side.
      steady = (ph == 6 || ph == 7);
      for (int n = 0; n < PHASE_ITEMS; n++) push_sample(pick_sample());
      steady = 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/assm_pkg.sv
hw/rtl/assm_front.sv
hw/rtl/assm_queue.sv
hw/rtl/assm_back.sv
hw/rtl/analog_stage_sample_model_unit.sv
test/analog_stage_sample_model_unit_test.sv
